@@ src/rsf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_pkg
// Shared widths, character codes, register indexes and types for the
// radix symbol formatter.
// ----------------------------------------------------------------------------
package rsf_pkg;

  localparam int NUM_W      = 32;
  localparam int SYM_W      = 8;
  localparam int MAX_BASE   = 16;
  localparam int NUM_SYMS   = 16;
  localparam int TBL_IDX_W  = $clog2(NUM_SYMS);
  localparam int TBL_W      = NUM_SYMS * SYM_W;
  localparam int DIGIT_W    = $clog2(MAX_BASE);
  localparam int RADIX_W    = 5;
  localparam int MAX_DIGITS = 32;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CHUNK_W    = 8;
  localparam int DIV_STEPS  = NUM_W / CHUNK_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int Q_DEPTH    = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  localparam logic [SYM_W-1:0] CHAR_MIN   = 8'd32;
  localparam logic [SYM_W-1:0] CHAR_MAX   = 8'd126;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] mag;
  } rsf_item_t;

  function automatic logic [SYM_W-1:0] sym_at(input logic [TBL_W-1:0] tbl,
                                              input logic [TBL_IDX_W-1:0] idx);
    return tbl[idx*SYM_W +: SYM_W];
  endfunction

endpackage

@@ src/radix_symbol_formatter_top.sv @@
`timescale 1ns / 1ps
// Flow: a number is written into the queue, then divided digit by digit (8 dividend bits a
//   cycle through the radix divider), then sent out one character at a time.
// A new number leaves the queue only once every character of the previous number
//   has gone to the output register.
// Reset: synchronous active-low rst_n; registers read zero, table invalid.
// ----------------------------------------------------------------------------
// radix_symbol_formatter_top
// Formats signed 32-bit numbers as characters in a configured radix.
// ----------------------------------------------------------------------------
module radix_symbol_formatter_top
  import rsf_pkg::*;
#(
  parameter int QUEUE_DEPTH = Q_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [NUM_W-1:0]      in_number,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SYM_W-1:0]      out_symbol,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [RADIX_W-1:0]    base_len_r;
  logic [CFG_DATA_W-1:0] sym_lo_r, sym_hi_r;
  logic [TBL_W-1:0]      symbols;

  logic      push, pop, q_full, q_valid;
  rsf_item_t push_item, head;

  assign cfg_ready = 1'b1;
  assign symbols   = {sym_hi_r, sym_lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_len_r <= '0;
      sym_lo_r   <= '0;
      sym_hi_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_LEN:     base_len_r <= cfg_data[RADIX_W-1:0];
        CFG_SYMBOLS_LOW:  sym_lo_r   <= cfg_data;
        CFG_SYMBOLS_HIGH: sym_hi_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  rsf_front u_front (
    .in_valid  (in_valid),
    .in_number (in_number),
    .q_full    (q_full),
    .radix     (base_len_r),
    .symbols   (symbols),
    .in_stall  (in_stall),
    .push      (push),
    .push_item (push_item)
  );

  rsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .head      (head)
  );

  rsf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head       (head),
    .radix      (base_len_r),
    .symbols    (symbols),
    .out_stall  (out_stall),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

`ifndef ASSERT_OFF
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_symbol == CHAR_MINUS) |-> !out_last)
    else $error("sign character flagged as last");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("queue written while full");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

@@ src/rsf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_front
// Accepts numbers, checks the symbol table and splits each number into sign
// and magnitude. Numbers seen with an invalid table are dropped.
// ----------------------------------------------------------------------------
module rsf_front
  import rsf_pkg::*;
(
  input  logic               in_valid,
  input  logic [NUM_W-1:0]   in_number,
  input  logic               q_full,
  input  logic [RADIX_W-1:0] radix,
  input  logic [TBL_W-1:0]   symbols,
  output logic               in_stall,
  output logic               push,
  output rsf_item_t          push_item
);

  logic table_ok;

  always_comb begin
    logic [SYM_W-1:0] c;
    table_ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_BASE));
    for (int i = 0; i < NUM_SYMS; i++) begin
      c = sym_at(symbols, TBL_IDX_W'(i));
      if (RADIX_W'(i) < radix) begin
        if (c < CHAR_MIN || c > CHAR_MAX || c == CHAR_MINUS || c == CHAR_PLUS) begin
          table_ok = 1'b0;
        end
        for (int j = i + 1; j < NUM_SYMS; j++) begin
          if (RADIX_W'(j) < radix && sym_at(symbols, TBL_IDX_W'(j)) == c) begin
            table_ok = 1'b0;
          end
        end
      end
    end
  end

  assign in_stall      = q_full;
  assign push          = in_valid && !q_full && table_ok;
  assign push_item.neg = in_number[NUM_W-1];
  assign push_item.mag = in_number[NUM_W-1] ? (NUM_W'(0) - in_number) : in_number;

endmodule

@@ src/rsf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_queue
// Small FIFO of classified numbers between the front and the back.
// ----------------------------------------------------------------------------
module rsf_queue
  import rsf_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rsf_item_t push_item,
  input  logic      pop,
  output logic      q_full,
  output logic      q_valid,
  output rsf_item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rsf_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ src/rsf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_back
// Splits a magnitude into digits by repeated division by the radix, eight
// dividend bits a cycle, then sends the sign and the digit symbols, most
// significant first, through an output register.
// ----------------------------------------------------------------------------
module rsf_back
  import rsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rsf_item_t          head,
  input  logic [RADIX_W-1:0] radix,
  input  logic [TBL_W-1:0]   symbols,
  input  logic               out_stall,
  output logic               pop,
  output logic               out_valid,
  output logic [SYM_W-1:0]   out_symbol,
  output logic               out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic               neg_r, neg_nxt;
  logic [NUM_W-1:0]   d_r, d_nxt, q_r, q_nxt;
  logic [RADIX_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [IDX_W-1:0]   nd_r, nd_nxt, rd_r, rd_nxt;
  logic [DIGIT_W-1:0] dig_r [MAX_DIGITS];
  logic               out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               last_r, last_nxt;

  logic [RADIX_W-1:0] rem_c;
  logic [CHUNK_W-1:0] qbits;
  logic [NUM_W-1:0]   q_full;
  logic               dig_we;
  logic               slot_free;

  always_comb begin
    logic [RADIX_W:0] t;
    rem_c = rem_r;
    qbits = '0;
    for (int k = 0; k < CHUNK_W; k++) begin
      t = {rem_c, d_r[NUM_W-1-k]};
      if (t >= {1'b0, radix}) begin
        t = t - {1'b0, radix};
        qbits[CHUNK_W-1-k] = 1'b1;
      end
      rem_c = t[RADIX_W-1:0];
    end
    q_full = {q_r[NUM_W-CHUNK_W-1:0], qbits};
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    d_nxt         = d_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    nd_nxt        = nd_r;
    rd_nxt        = rd_r;
    dig_we        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          neg_nxt   = head.neg;
          d_nxt     = head.mag;
          q_nxt     = '0;
          rem_nxt   = '0;
          step_nxt  = '0;
          nd_nxt    = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        d_nxt    = {d_r[NUM_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
        q_nxt    = q_full;
        rem_nxt  = rem_c;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          dig_we   = 1'b1;
          d_nxt    = q_full;
          q_nxt    = '0;
          rem_nxt  = '0;
          step_nxt = '0;
          nd_nxt   = nd_r + IDX_W'(1);
          if (q_full == '0 || nd_r == IDX_W'(MAX_DIGITS - 1)) begin
            rd_nxt    = nd_r;
            state_nxt = neg_r ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          sym_nxt       = CHAR_MINUS;
          last_nxt      = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          sym_nxt       = sym_at(symbols, TBL_IDX_W'(dig_r[rd_r]));
          last_nxt      = (rd_r == '0);
          rd_nxt        = rd_r - IDX_W'(1);
          if (rd_r == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    d_r    <= d_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    nd_r   <= nd_nxt;
    rd_r   <= rd_nxt;
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
    if (dig_we) begin
      dig_r[nd_r] <= rem_c[DIGIT_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = sym_r;
  assign out_last   = last_r;

endmodule
